[sv/mes_pkg.sv]
// Shared types, constants and the frequency-number table for the note-event sequencer.
// No dependencies; mes_evt, the top level and the checker refer to it by scoped names.
package mes_pkg;

  // Table depth is a power of two: load slots wrap by truncation; the read index wraps by an explicit compare.
  localparam int TableDepth       = 128;
  localparam int MaxEventsPerTick = 32;
  localparam int IdxW             = $clog2(TableDepth);
  localparam int PlayCntW         = $clog2(MaxEventsPerTick + 1);

  localparam logic [15:0] EndTick  = 16'hFFFF;
  localparam logic [7:0]  BaseFnum = 8'hA0;
  localparam logic [7:0]  BaseKey  = 8'hB0;
  localparam logic [7:0]  KeyOnBit = 8'h20;
  localparam logic [7:0]  NumNotes = 8'd12;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WR_A,
    ST_WR_B,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] tick;
    logic [3:0]  channel;
    logic [7:0]  note;
    logic [2:0]  octave;
  } entry_t;

  // Decoded view of one table entry against the current play tick.
  typedef struct packed {
    logic       due;
    logic       sentinel;
    logic       key_on;
    logic [7:0] a_addr;
    logic [7:0] a_value;
    logic [7:0] b_addr;
    logic [7:0] b_value;
  } evt_t;

  function automatic logic [9:0] freq_number(input logic [3:0] semitone);
    logic [9:0] fn;
    case (semitone)
      4'd0:    fn = 10'h157;
      4'd1:    fn = 10'h16B;
      4'd2:    fn = 10'h181;
      4'd3:    fn = 10'h198;
      4'd4:    fn = 10'h1B0;
      4'd5:    fn = 10'h1CA;
      4'd6:    fn = 10'h1E5;
      4'd7:    fn = 10'h202;
      4'd8:    fn = 10'h220;
      4'd9:    fn = 10'h241;
      4'd10:   fn = 10'h263;
      4'd11:   fn = 10'h287;
      default: fn = 10'h000;
    endcase
    return fn;
  endfunction

endpackage

[sv/mes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mes_ram #(
  parameter int Width = 31,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mes_evt.sv]
// Event decoder: due/sentinel compare against the play tick and the two register writes.
// Depends on mes_pkg.
module mes_evt (
  input  mes_pkg::entry_t entry_i,
  input  logic [15:0]     play_tick_i,
  output mes_pkg::evt_t   evt_o
);

  logic [9:0] fn;

  assign fn = mes_pkg::freq_number(entry_i.note[3:0]);

  always_comb begin
    evt_o.sentinel = (entry_i.tick == mes_pkg::EndTick);
    evt_o.due      = !evt_o.sentinel && (entry_i.tick <= play_tick_i);
    evt_o.key_on   = (entry_i.note < mes_pkg::NumNotes);
    evt_o.a_addr   = mes_pkg::BaseFnum + {4'd0, entry_i.channel};
    evt_o.a_value  = fn[7:0];
    evt_o.b_addr   = mes_pkg::BaseKey + {4'd0, entry_i.channel};
    // Note-off (and any out-of-range note) clears the key-on byte.
    evt_o.b_value  = evt_o.key_on ?
                     (mes_pkg::KeyOnBit | {3'd0, entry_i.octave, fn[9:8]}) : 8'd0;
  end

endmodule

[sv/music_event_sequencer_core.sv]
// Note-event sequencer top level. Load and restart transactions are taken while idle and start no walk.
// A tick transaction walks up to 32 due events: per event a RAM read, a compare and one write
// (note-off) or two (key-on) through the hold register, then a check of the stopping entry and
// the release of the last write before ready returns; output back-pressure stalls the writes.
// Reset (rst_ni low, asynchronous) clears the read index, the play tick and all control.
module music_event_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  entry_index_i,
  input  logic [15:0] event_tick_i,
  input  logic [3:0]  event_channel_i,
  input  logic [7:0]  event_note_i,
  input  logic [2:0]  event_octave_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  reg_addr_o,
  output logic [7:0]  reg_value_o,
  output logic        last_o
);

  localparam int IdxW = mes_pkg::IdxW;
  localparam int CntW = mes_pkg::PlayCntW;

  mes_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     tick_q, tick_d;
  logic [CntW-1:0] played_q, played_d;

  // One-deep hold for the newest write: its last flag is known only once the walk
  // decides whether another write follows.
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_addr_q, pend_addr_d;
  logic [7:0] pend_value_q, pend_value_d;

  // Output register toward the consumer.
  logic       ovalid_q, ovalid_d;
  logic [7:0] oaddr_q, oaddr_d;
  logic [7:0] ovalue_q, ovalue_d;
  logic       olast_q, olast_d;

  logic       ram_we;
  logic [IdxW-1:0] load_slot;
  mes_pkg::entry_t wr_entry, rd_entry;
  mes_pkg::evt_t   evt;

  logic       can_push;
  logic       push;
  logic       flush;
  logic [7:0] push_addr;
  logic [7:0] push_value;

  // Slot wraps modulo the table depth.
  assign load_slot = IdxW'(entry_index_i);

  assign wr_entry.tick    = event_tick_i;
  assign wr_entry.channel = event_channel_i;
  assign wr_entry.note    = event_note_i;
  assign wr_entry.octave  = event_octave_i;

  mes_ram #(
    .Width ($bits(mes_pkg::entry_t)),
    .Depth (mes_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_slot),
    .wdata_i (wr_entry),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  // Shared compare and formatting unit, reused once per walked event.
  mes_evt u_evt (
    .entry_i     (rd_entry),
    .play_tick_i (tick_q),
    .evt_o       (evt)
  );

  assign can_push = !ovalid_q || out_ready_i;

  // Sequencer: next state and counters.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    tick_d     = tick_q;
    played_d   = played_q;
    ram_we     = 1'b0;
    push       = 1'b0;
    flush      = 1'b0;
    push_addr  = evt.b_addr;
    push_value = evt.b_value;

    case (state_q)
      mes_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            mes_pkg::CMD_LOAD: begin
              ram_we = 1'b1;
            end
            mes_pkg::CMD_TICK: begin
              played_d = '0;
              state_d  = mes_pkg::ST_READ;
            end
            mes_pkg::CMD_RESTART: begin
              idx_d  = '0;
              tick_d = '0;
            end
            default: begin
              // Unused command: drop it.
            end
          endcase
        end
      end
      mes_pkg::ST_READ: begin
        // RAM read of idx_q lands next cycle.
        state_d = mes_pkg::ST_CHECK;
      end
      mes_pkg::ST_CHECK: begin
        if (played_q == CntW'(mes_pkg::MaxEventsPerTick) || !evt.due) begin
          // Walk ends; the entry at idx_q decides wrap or advance.
          if (evt.sentinel) begin
            idx_d  = '0;
            tick_d = '0;
          end else begin
            tick_d = tick_q + 16'd1;
          end
          state_d = mes_pkg::ST_FLUSH;
        end else if (evt.key_on) begin
          state_d = mes_pkg::ST_WR_A;
        end else begin
          state_d = mes_pkg::ST_WR_B;
        end
      end
      mes_pkg::ST_WR_A: begin
        if (can_push) begin
          push       = 1'b1;
          push_addr  = evt.a_addr;
          push_value = evt.a_value;
          state_d    = mes_pkg::ST_WR_B;
        end
      end
      mes_pkg::ST_WR_B: begin
        if (can_push) begin
          push     = 1'b1;
          idx_d    = (idx_q == IdxW'(mes_pkg::TableDepth - 1)) ? '0 : idx_q + IdxW'(1);
          played_d = played_q + CntW'(1);
          state_d  = mes_pkg::ST_READ;
        end
      end
      mes_pkg::ST_FLUSH: begin
        // Release the held write as the last one of this tick.
        if (!pend_valid_q) begin
          state_d = mes_pkg::ST_IDLE;
        end else if (can_push) begin
          flush   = 1'b1;
          state_d = mes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mes_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold register and output register.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    pend_value_d = pend_value_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    oaddr_d      = oaddr_q;
    ovalue_d     = ovalue_q;
    olast_d      = olast_q;

    // Advance the held write to the output whenever a newer one arrives or on flush.
    if ((push && pend_valid_q) || flush) begin
      ovalid_d = 1'b1;
      oaddr_d  = pend_addr_q;
      ovalue_d = pend_value_q;
      olast_d  = flush;
    end
    if (push) begin
      pend_valid_d = 1'b1;
      pend_addr_d  = push_addr;
      pend_value_d = push_value;
    end else if (flush) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mes_pkg::ST_IDLE;
      idx_q        <= '0;
      tick_q       <= '0;
      played_q     <= '0;
      pend_valid_q <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      tick_q       <= tick_d;
      played_q     <= played_d;
      pend_valid_q <= pend_valid_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    pend_value_q <= pend_value_d;
    oaddr_q      <= oaddr_d;
    ovalue_q     <= ovalue_d;
    olast_q      <= olast_d;
  end

  assign in_ready_o  = (state_q == mes_pkg::ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign reg_addr_o  = oaddr_q;
  assign reg_value_o = ovalue_q;
  assign last_o      = olast_q;

endmodule

[sv/mes_chk.sv]
// Port-level checker for the note-event sequencer, bound to the top level.
// Depends on mes_pkg for command codes.
module mes_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  reg_addr_o,
  input logic [7:0]  reg_value_o,
  input logic        last_o
);

  // A stalled write stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("write dropped while stalled");

  // A stalled write keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(reg_addr_o) && $stable(reg_value_o) && $stable(last_o))
    else $error("write payload changed while stalled");

  // A tick transaction starts a walk: no new transaction in the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == mes_pkg::CMD_TICK |=> !in_ready_o)
    else $error("tick walk did not hold off input");

  // Load and restart never produce a write.
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    (cmd_i == mes_pkg::CMD_LOAD || cmd_i == mes_pkg::CMD_RESTART) |=> !out_valid_o)
    else $error("write produced by load or restart");

endmodule

bind music_event_sequencer_core mes_chk u_mes_chk (.*);
